// File: hw/rtl/mevq_pkg.sv
// Package for the mouse event qualifier: payload structs, register indexes,
// event device codes and result-slot layout. No dependencies.
package mevq_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned NoiseW = 15;
    localparam int unsigned EnableW = 7;
    localparam int unsigned TieW = 12;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    // Result slots: three per button (event, tie 0, tie 1), then x, y and
    // the empty result that an acting tick without events produces.
    localparam int unsigned NumSlots = 12;
    localparam int unsigned SlotX = 9;
    localparam int unsigned SlotY = 10;
    localparam int unsigned SlotEmpty = 11;

    typedef enum logic [CfgIdxW-1:0] {
        REG_X_MIN = 3'd0,
        REG_X_MAX = 3'd1,
        REG_Y_MIN = 3'd2,
        REG_Y_MAX = 3'd3,
        REG_NOISE_X = 3'd4,
        REG_NOISE_Y = 3'd5,
        REG_ENABLE = 3'd6,
        REG_TIE_SEL = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        DEV_RIGHT = 3'd0,
        DEV_MIDDLE = 3'd1,
        DEV_LEFT = 3'd2,
        DEV_MOUSE_X = 3'd3,
        DEV_MOUSE_Y = 3'd4
    } device_t;

    typedef enum logic [1:0] {
        TIE_NONE = 2'd0,
        TIE_MOUSE_X = 2'd1,
        TIE_MOUSE_Y = 2'd2,
        TIE_UNUSED = 2'd3
    } tie_t;

    localparam int unsigned EnQueueX = 3;
    localparam int unsigned EnQueueY = 4;
    localparam int unsigned EnCursorX = 5;
    localparam int unsigned EnCursorY = 6;

    typedef struct packed {
        logic [2:0] buttons;
        logic signed [CoordW-1:0] raw_x;
        logic signed [CoordW-1:0] raw_y;
    } in_item_t;

    typedef struct packed {
        logic event_valid;
        logic [2:0] event_device;
        logic signed [CoordW-1:0] event_value;
        logic last_of_tick;
        logic signed [CoordW-1:0] clamped_x;
        logic signed [CoordW-1:0] clamped_y;
        logic cursor_x_update;
        logic cursor_y_update;
    } out_item_t;

    typedef struct packed {
        logic [2:0] device;
        logic signed [CoordW-1:0] value;
    } slot_t;

endpackage

// File: hw/rtl/mouse_event_qualifier.sv
// Mouse event qualifier top level: input register, single-pass event
// builder and a slot buffer that hands out one result per cycle whenever
// m_ready is high. Depends on mevq_pkg.
//
// A tick in the input register is loaded into the slot buffer when the
//   buffer is free; an acting tick's first result is valid from then.
// An acting tick occupies the slot buffer until all its results (1 to 11)
//   have left; a skipped tick passes through and yields none. The buffer
//   takes the next tick as the final result leaves the single result port.
// Reset: aresetn is synchronous and active low. It clears the handshake
//   state, the sampling state and the registers to their documented values.
module mouse_event_qualifier
    import mevq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    // Configuration registers.
    logic signed [CoordW-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [NoiseW-1:0]        noise_x_reg, noise_y_reg;
    logic [EnableW-1:0]       enable_reg;
    logic [TieW-1:0]          tie_sel_reg;

    // Sampling state carried from one acting tick to the next.
    logic                     phase_reg;
    logic [2:0]               levels_reg;
    logic signed [CoordW-1:0] pub_x_reg, pub_y_reg, queued_x_reg, queued_y_reg;

    // Input register.
    logic     in_valid_reg;
    in_item_t in_data_reg;

    // Slot buffer: one entry per possible result of a tick, with a mask of
    // those still to be delivered. Lower slots go out first.
    slot_t                    slot_reg [NumSlots];
    logic [NumSlots-1:0]      mask_reg;
    logic signed [CoordW-1:0] clamped_x_reg, clamped_y_reg;
    logic                     cur_x_reg, cur_y_reg;

    // Combinational event builder.
    slot_t                    slot_next [NumSlots];
    logic [NumSlots-1:0]      mask_next;
    logic signed [CoordW-1:0] cx, cy;
    logic signed [CoordW:0]   dx, dy;
    logic [CoordW:0]          adx, ady;
    logic                     emit_x, emit_y, acting;
    logic [1:0]               tie_code;

    // Output selection.
    logic [NumSlots-1:0] pick;
    logic [NumSlots-1:0] mask_rest;
    logic                last_result;
    logic                buf_free;
    logic                load;
    slot_t               out_slot;

    assign cfg_ready = 1'b1;

    // The buffer can take a new tick when it is empty, or when its final
    // result leaves in this very cycle.
    assign mask_rest   = mask_reg & (mask_reg - NumSlots'(1));
    assign pick        = mask_reg & ~mask_rest;
    assign last_result = (mask_rest == '0);
    assign m_valid     = |mask_reg;
    assign buf_free    = !m_valid || (m_ready && last_result);
    assign load        = in_valid_reg && buf_free;
    assign s_ready     = !in_valid_reg || load;

    // Phase is toggled by every tick; the tick acts when the toggle sets it
    // back to zero, so the first tick after reset is skipped.
    assign acting = phase_reg;

    always_comb begin
        // Clamp: apply the minimum first so that the maximum wins when the
        // limits cross.
        cx = (in_data_reg.raw_x < x_min_reg) ? x_min_reg : in_data_reg.raw_x;
        cx = (cx > x_max_reg) ? x_max_reg : cx;
        cy = (in_data_reg.raw_y < y_min_reg) ? y_min_reg : in_data_reg.raw_y;
        cy = (cy > y_max_reg) ? y_max_reg : cy;

        // Exact distance in one extra bit, then its magnitude.
        dx  = {cx[CoordW-1], cx} - {queued_x_reg[CoordW-1], queued_x_reg};
        dy  = {cy[CoordW-1], cy} - {queued_y_reg[CoordW-1], queued_y_reg};
        adx = dx[CoordW] ? (CoordW+1)'(-dx) : dx;
        ady = dy[CoordW] ? (CoordW+1)'(-dy) : dy;

        emit_x = enable_reg[EnQueueX] && (adx >= {2'b00, noise_x_reg});
        emit_y = enable_reg[EnQueueY] && (ady >= {2'b00, noise_y_reg});

        mask_next = '0;
        tie_code  = TIE_NONE;
        for (int b = 0; b < 3; b++) begin
            slot_next[3*b].device = 3'(b);
            slot_next[3*b].value  = CoordW'(in_data_reg.buttons[b]);
            mask_next[3*b] = enable_reg[b] && (in_data_reg.buttons[b] != levels_reg[b]);
            for (int t = 0; t < 2; t++) begin
                tie_code = tie_sel_reg[2*(2*b+t) +: 2];
                case (tie_code)
                    TIE_MOUSE_X: begin
                        slot_next[3*b+1+t].device = DEV_MOUSE_X;
                        slot_next[3*b+1+t].value  = pub_x_reg;
                        mask_next[3*b+1+t] = mask_next[3*b];
                    end
                    TIE_MOUSE_Y: begin
                        slot_next[3*b+1+t].device = DEV_MOUSE_Y;
                        slot_next[3*b+1+t].value  = pub_y_reg;
                        mask_next[3*b+1+t] = mask_next[3*b];
                    end
                    default: begin
                        slot_next[3*b+1+t].device = DEV_RIGHT;
                        slot_next[3*b+1+t].value  = '0;
                        mask_next[3*b+1+t] = 1'b0;
                    end
                endcase
            end
        end
        slot_next[SlotX].device     = DEV_MOUSE_X;
        slot_next[SlotX].value      = cx;
        mask_next[SlotX]            = emit_x;
        slot_next[SlotY].device     = DEV_MOUSE_Y;
        slot_next[SlotY].value      = cy;
        mask_next[SlotY]            = emit_y;
        slot_next[SlotEmpty].device = DEV_RIGHT;
        slot_next[SlotEmpty].value  = '0;
        mask_next[SlotEmpty]        = (mask_next[SlotEmpty-1:0] == '0);

        // A skipped tick yields nothing.
        if (!acting) begin
            mask_next = '0;
        end
    end

    // The picked slot is one-hot, so an OR of the masked entries selects it.
    always_comb begin
        out_slot = '0;
        for (int i = 0; i < NumSlots; i++) begin
            if (pick[i]) begin
                out_slot = out_slot | slot_reg[i];
            end
        end
    end

    always_comb begin
        m_data.event_valid     = !pick[SlotEmpty];
        m_data.event_device    = out_slot.device;
        m_data.event_value     = out_slot.value;
        m_data.last_of_tick    = last_result;
        m_data.clamped_x       = clamped_x_reg;
        m_data.clamped_y       = clamped_y_reg;
        m_data.cursor_x_update = cur_x_reg;
        m_data.cursor_y_update = cur_y_reg;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg   <= 16'sh8000;
            x_max_reg   <= 16'sh7FFF;
            y_min_reg   <= 16'sh8000;
            y_max_reg   <= 16'sh7FFF;
            noise_x_reg <= NoiseW'(1);
            noise_y_reg <= NoiseW'(1);
            enable_reg  <= '0;
            tie_sel_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_X_MIN:   x_min_reg   <= cfg_wdata;
                REG_X_MAX:   x_max_reg   <= cfg_wdata;
                REG_Y_MIN:   y_min_reg   <= cfg_wdata;
                REG_Y_MAX:   y_max_reg   <= cfg_wdata;
                REG_NOISE_X: noise_x_reg <= cfg_wdata[NoiseW-1:0];
                REG_NOISE_Y: noise_y_reg <= cfg_wdata[NoiseW-1:0];
                REG_ENABLE:  enable_reg  <= cfg_wdata[EnableW-1:0];
                REG_TIE_SEL: tie_sel_reg <= cfg_wdata[TieW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: control under reset, payload without.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Slot mask and sampling state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            phase_reg    <= 1'b0;
            levels_reg   <= '0;
            pub_x_reg    <= '0;
            pub_y_reg    <= '0;
            queued_x_reg <= '0;
            queued_y_reg <= '0;
        end else if (load) begin
            mask_reg  <= mask_next;
            phase_reg <= !phase_reg;
            if (acting) begin
                levels_reg <= in_data_reg.buttons;
                pub_x_reg  <= cx;
                pub_y_reg  <= cy;
                if (emit_x) begin
                    queued_x_reg <= cx;
                end
                if (emit_y) begin
                    queued_y_reg <= cy;
                end
            end
        end else if (m_valid && m_ready) begin
            mask_reg <= mask_rest;
        end
    end

    // Slot payload.
    always_ff @(posedge aclk) begin
        if (load && acting) begin
            for (int i = 0; i < NumSlots; i++) begin
                slot_reg[i] <= slot_next[i];
            end
            clamped_x_reg <= cx;
            clamped_y_reg <= cy;
            cur_x_reg     <= enable_reg[EnCursorX];
            cur_y_reg     <= enable_reg[EnCursorY];
        end
    end

    // An acting tick always leaves at least one result in the buffer.
    a_acting_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        load && acting |=> m_valid)
        else $error("acting tick produced no result");

    // A skipped tick never leaves results behind.
    a_skip_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !acting |=> !m_valid)
        else $error("skipped tick produced a result");

    // The empty result only ever stands alone as the last of its tick.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.event_valid |-> m_data.last_of_tick)
        else $error("result without event is not the last of its tick");

    // The last result is flagged exactly when one slot remains.
    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_tick == ($countones(mask_reg) == 1)))
        else $error("last_of_tick disagrees with the slot mask");

    // A stalled result leaves the buffer untouched.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(mask_reg))
        else $error("slot mask changed while the result was stalled");

endmodule
